// ===== sv/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// slt_pkg
// Shared constants, command and status codes and the control structs of the
// scope lifetime tracker.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int MAX_SCOPES = 512;

    // port field widths
    localparam int CMD_W   = 2;
    localparam int SID_W   = 10;
    localparam int NEW_W   = 9;
    localparam int STAT_W  = 2;
    localparam int EXP_W   = 9;
    localparam int DEPTH_W = 10;

    // internal widths
    localparam int ID_AW    = $clog2(MAX_SCOPES);
    localparam int CNT_W    = $clog2(MAX_SCOPES + 1);
    localparam int ROW_W    = 16;
    localparam int BIT_AW   = $clog2(ROW_W);
    localparam int MAP_ROWS = MAX_SCOPES / ROW_W;
    localparam int ROW_AW   = $clog2(MAP_ROWS);

    typedef enum logic [CMD_W-1:0] {
        OP_ENTER = 2'd0,
        OP_EXIT  = 2'd1,
        OP_CHECK = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_MISMATCH  = 2'd3
    } status_t;

    typedef struct packed {
        logic accept;
        logic commit;
    } ctrl_t;

    typedef struct packed {
        logic slot_free;
    } dp_sts_t;

endpackage

// ===== sv/slt_cmd_if.sv =====
// ----------------------------------------------------------------------------
// slt_cmd_if
// Command channel: valid/ready handshake with opcode and scope identifier.
// ----------------------------------------------------------------------------
interface slt_cmd_if
    import slt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [SID_W-1:0] target_id;

    modport source (output valid, output cmd, output target_id, input ready);
    modport sink   (input valid, input cmd, input target_id, output ready);
endinterface

// ===== sv/slt_res_if.sv =====
// ----------------------------------------------------------------------------
// slt_res_if
// Result channel: valid/ready handshake with one result per command.
// ----------------------------------------------------------------------------
interface slt_res_if
    import slt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [NEW_W-1:0]   new_scope;
    logic               valid_res;
    logic [STAT_W-1:0]  status;
    logic [EXP_W-1:0]   popped_id;
    logic [DEPTH_W-1:0] depth;

    modport source (output valid, output new_scope, output valid_res, output status,
                    output popped_id, output depth, input ready);
    modport sink   (input valid, input new_scope, input valid_res, input status,
                    input popped_id, input depth, output ready);
endinterface

// ===== sv/scope_lifetime_tracker.sv =====
// ----------------------------------------------------------------------------
// scope_lifetime_tracker
// Nested scope lifetime tracker for use-after-scope checks.
//
// req carries one command per transaction (enter, exit, check, clear) with a
// scope identifier; rsp returns exactly one result transaction per command,
// in order.
// On acceptance the command is registered and the memories are read; the
// result register is loaded when the command commits from the execute state.
// Each command needs a registered read of the bitmap row memory and the stack
// memory before it commits, and no new command is taken until it has.
// req.ready is high whenever no command is in flight; a finished result sits
// in the output register, so the next command is taken while it waits.
// If rsp stalls, the following command holds before its commit until the
// output register is taken, and req.ready stays low meanwhile.
// Reset clears the counter to one, the stack depth to zero and every bitmap
// row valid bit, so all identifiers read as inactive at once; no clearing
// pass is needed. The clear command does the same.
// Overflow and underflow return an error status and change no state.
// ----------------------------------------------------------------------------
module scope_lifetime_tracker
    import slt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    slt_cmd_if.sink    req,
    slt_res_if.source  rsp
);

    ctrl_t   ctrl;
    dp_sts_t sts;

    slt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .ctrl      (ctrl)
    );

    slt_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .sts           (sts),
        .req_cmd       (req.cmd),
        .req_target_id (req.target_id),
        .rsp_valid     (rsp.valid),
        .rsp_ready     (rsp.ready),
        .rsp_new_scope (rsp.new_scope),
        .rsp_valid_res (rsp.valid_res),
        .rsp_status    (rsp.status),
        .rsp_popped_id (rsp.popped_id),
        .rsp_depth     (rsp.depth)
    );

    // a commit always leaves a result waiting
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit |=> rsp.valid)
        else $error("commit did not load the result register");

    // only one command in flight
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("command accepted while another is in flight");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == STAT_OVERFLOW) |->
        (rsp.new_scope == '0 && rsp.depth == DEPTH_W'(MAX_SCOPES)))
        else $error("overflow reported with stack not full");

    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == STAT_UNDERFLOW) |->
        (rsp.depth == '0 && rsp.popped_id == '0))
        else $error("underflow reported with stack not empty");

endmodule

// ===== sv/slt_ram.sv =====
// ----------------------------------------------------------------------------
// slt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module slt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/slt_ctrl.sv =====
// ----------------------------------------------------------------------------
// slt_ctrl
// Controller: accepts a command, moves to the execute state while the memory
// reads complete and commits once the result slot is free.
// ----------------------------------------------------------------------------
module slt_ctrl
    import slt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    input  dp_sts_t sts,
    output ctrl_t   ctrl
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        req_ready   = (state_reg == S_IDLE);
        ctrl.accept = req_valid && (state_reg == S_IDLE);
        ctrl.commit = (state_reg == S_EXEC) && sts.slot_free;
        state_next  = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (ctrl.accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (ctrl.commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/slt_dp.sv =====
// ----------------------------------------------------------------------------
// slt_dp
// Datapath: identifier counter, stack depth, active bitmap in row memory
// with per-row valid bits, scope stack memory and the result register.
// ----------------------------------------------------------------------------
module slt_dp
    import slt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_t              ctrl,
    output dp_sts_t            sts,
    input  logic [CMD_W-1:0]   req_cmd,
    input  logic [SID_W-1:0]   req_target_id,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic [NEW_W-1:0]   rsp_new_scope,
    output logic               rsp_valid_res,
    output logic [STAT_W-1:0]  rsp_status,
    output logic [EXP_W-1:0]   rsp_popped_id,
    output logic [DEPTH_W-1:0] rsp_depth
);

    // architectural state
    logic [CNT_W-1:0]    next_scope_reg, next_scope_next;
    logic [CNT_W-1:0]    depth_reg, depth_next;
    logic [MAP_ROWS-1:0] row_valid_reg, row_valid_next;

    // command held across the read cycle
    op_t                 op_reg;
    logic [SID_W-1:0]    sid_reg;
    logic [ID_AW-1:0]    map_idx_reg;

    // result register
    logic                out_valid_reg, out_valid_next;
    logic [NEW_W-1:0]    new_scope_reg, new_scope_next;
    logic                valid_res_reg, valid_res_next;
    status_t             status_reg, status_next;
    logic [EXP_W-1:0]    expected_reg, expected_next;
    logic [DEPTH_W-1:0]  depth_out_reg, depth_out_next;

    // memory ports
    logic [ID_AW-1:0]    alloc_id;
    logic [ID_AW-1:0]    map_idx_in;
    logic [ROW_W-1:0]    map_rdata;
    logic [ROW_W-1:0]    map_wdata;
    logic                map_we;
    logic [ID_AW-1:0]    stack_raddr;
    logic [ID_AW-1:0]    stack_rdata;
    logic                stack_we;

    logic [ROW_AW-1:0]   row_sel;
    logic [BIT_AW-1:0]   bit_sel;
    logic [ROW_W-1:0]    bit_mask;
    logic [ROW_W-1:0]    row_eff;
    logic                sid_ok;

    assign sts.slot_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        if (next_scope_reg >= CNT_W'(MAX_SCOPES) || next_scope_reg == '0)
        begin
            alloc_id = ID_AW'(1);
        end
        else
        begin
            alloc_id = next_scope_reg[ID_AW-1:0];
        end
        if (op_t'(req_cmd) == OP_ENTER)
        begin
            map_idx_in = alloc_id;
        end
        else
        begin
            map_idx_in = ID_AW'(req_target_id);
        end
        stack_raddr = ID_AW'(depth_reg - CNT_W'(1));
    end

    assign row_sel  = map_idx_reg[ID_AW-1:BIT_AW];
    assign bit_sel  = map_idx_reg[BIT_AW-1:0];
    assign bit_mask = ROW_W'(1) << bit_sel;
    // a row not written since the last clear reads as all inactive
    assign row_eff  = row_valid_reg[row_sel] ? map_rdata : '0;
    assign sid_ok   = (sid_reg != '0) && (32'(sid_reg) < 32'(MAX_SCOPES));

    always_comb
    begin
        next_scope_next = next_scope_reg;
        depth_next      = depth_reg;
        row_valid_next  = row_valid_reg;
        map_we          = 1'b0;
        map_wdata       = row_eff;
        stack_we        = 1'b0;
        new_scope_next  = new_scope_reg;
        valid_res_next  = valid_res_reg;
        status_next     = status_reg;
        expected_next   = expected_reg;
        depth_out_next  = depth_out_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;

        if (ctrl.commit)
        begin
            out_valid_next = 1'b1;
            new_scope_next = '0;
            valid_res_next = 1'b0;
            status_next    = STAT_OK;
            expected_next  = '0;
            case (op_reg)
                OP_ENTER:
                begin
                    if (depth_reg == CNT_W'(MAX_SCOPES))
                    begin
                        status_next = STAT_OVERFLOW;
                    end
                    else
                    begin
                        next_scope_next         = CNT_W'(map_idx_reg) + CNT_W'(1);
                        depth_next              = depth_reg + CNT_W'(1);
                        map_we                  = 1'b1;
                        map_wdata               = row_eff | bit_mask;
                        row_valid_next[row_sel] = 1'b1;
                        stack_we                = 1'b1;
                        new_scope_next          = NEW_W'(map_idx_reg);
                    end
                end
                OP_EXIT:
                begin
                    if (depth_reg == '0)
                    begin
                        status_next = STAT_UNDERFLOW;
                    end
                    else
                    begin
                        depth_next    = depth_reg - CNT_W'(1);
                        expected_next = EXP_W'(stack_rdata);
                        if (32'(stack_rdata) != 32'(sid_reg))
                        begin
                            status_next = STAT_MISMATCH;
                        end
                        if (sid_ok)
                        begin
                            map_we                  = 1'b1;
                            map_wdata               = row_eff & ~bit_mask;
                            row_valid_next[row_sel] = 1'b1;
                        end
                    end
                end
                OP_CHECK:
                begin
                    valid_res_next = sid_ok && row_eff[bit_sel];
                end
                default:
                begin
                    // clear all tracking
                    next_scope_next = CNT_W'(1);
                    depth_next      = '0;
                    row_valid_next  = '0;
                end
            endcase
            depth_out_next = DEPTH_W'(depth_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_scope_reg <= CNT_W'(1);
            depth_reg      <= '0;
            row_valid_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            next_scope_reg <= next_scope_next;
            depth_reg      <= depth_next;
            row_valid_reg  <= row_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            op_reg      <= op_t'(req_cmd);
            sid_reg     <= req_target_id;
            map_idx_reg <= map_idx_in;
        end
        new_scope_reg <= new_scope_next;
        valid_res_reg <= valid_res_next;
        status_reg    <= status_next;
        expected_reg  <= expected_next;
        depth_out_reg <= depth_out_next;
    end

    slt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAP_ROWS)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (row_sel),
        .wdata (map_wdata),
        .re    (ctrl.accept),
        .raddr (map_idx_in[ID_AW-1:BIT_AW]),
        .rdata (map_rdata)
    );

    slt_ram #(
        .WIDTH (ID_AW),
        .DEPTH (MAX_SCOPES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (depth_reg[ID_AW-1:0]),
        .wdata (map_idx_reg),
        .re    (ctrl.accept),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    assign rsp_valid     = out_valid_reg;
    assign rsp_new_scope = new_scope_reg;
    assign rsp_valid_res = valid_res_reg;
    assign rsp_status    = status_reg;
    assign rsp_popped_id = expected_reg;
    assign rsp_depth     = depth_out_reg;

endmodule

// ===== test/tb_scope_lifetime_tracker.sv =====
// ----------------------------------------------------------------------------
// tb_scope_lifetime_tracker
// Self-checking bench for the scope lifetime tracker. Commands go in through
// the req channel with bursty timing while rsp stalls on its own schedule.
// A behavioural copy of the tracker (counter, active bitmap, id stack) works
// out every expected result in order, and each result transaction is checked
// field by field against it. Directed tests cover nesting, exit order
// mismatch, invalid identifiers, clear, counter wrap, overflow and underflow;
// random phases then run mostly well-nested traffic with some noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_scope_lifetime_tracker;
    import slt_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam logic [15:0] STALL_PATTERN = 16'b1011_0111_0010_1101;

    typedef enum {SINK_OPEN, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

    typedef struct packed {
        logic [NEW_W-1:0]   new_scope;
        logic               valid_res;
        status_t            status;
        logic [EXP_W-1:0]   popped_id;
        logic [DEPTH_W-1:0] depth;
    } scope_result_t;

    logic clk = 1'b0;
    logic rst_n;

    slt_cmd_if req_if ();
    slt_res_if res_ch ();

    scope_lifetime_tracker dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (res_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // behavioural copy of the tracker state
    logic [CNT_W-1:0]   next_id;
    bit [MAX_SCOPES-1:0] live_map;
    logic [ID_AW-1:0]   id_stack [MAX_SCOPES];
    logic [DEPTH_W-1:0] stack_level;

    scope_result_t pending_results [$];
    int unsigned   errors = 0;
    int unsigned   quiet_cycles = 0;

    bit          cmd_up = 1'b0;
    bit          bursty = 1'b0;
    int unsigned burst_left = 0;

    sink_mode_t sink_mode = SINK_OPEN;
    bit         sink_ready;
    logic [3:0] sink_phase = '0;

    assign res_ch.ready = sink_ready;

    function automatic void forget_all_scopes();
        next_id     = CNT_W'(1);
        live_map    = '0;
        stack_level = '0;
    endfunction

    function automatic scope_result_t track_command(op_t op, logic [SID_W-1:0] sid);
        scope_result_t    r;
        logic [ID_AW-1:0] id;
        bit               sid_ok;
        r        = '0;
        r.status = STAT_OK;
        sid_ok   = (sid != 0) && (sid < MAX_SCOPES);
        case (op)
            OP_ENTER:
            begin
                if (stack_level >= MAX_SCOPES)
                begin
                    r.status = STAT_OVERFLOW;
                end
                else
                begin
                    // counter wraps back to one
                    if (next_id >= MAX_SCOPES || next_id == 0)
                        next_id = CNT_W'(1);
                    id                                 = next_id[ID_AW-1:0];
                    next_id                            = next_id + 1'b1;
                    live_map[id]                       = 1'b1;
                    id_stack[stack_level[ID_AW-1:0]]   = id;
                    stack_level                        = stack_level + 1'b1;
                    r.new_scope                        = id;
                end
            end
            OP_EXIT:
            begin
                if (stack_level == 0)
                begin
                    r.status = STAT_UNDERFLOW;
                end
                else
                begin
                    stack_level = stack_level - 1'b1;
                    r.popped_id = id_stack[stack_level[ID_AW-1:0]];
                    if ({1'b0, r.popped_id} != sid)
                        r.status = STAT_MISMATCH;
                    // the given id is cleared even when the order is wrong
                    if (sid_ok)
                        live_map[sid[ID_AW-1:0]] = 1'b0;
                end
            end
            OP_CHECK:
            begin
                if (sid_ok)
                    r.valid_res = live_map[sid[ID_AW-1:0]];
            end
            default:
            begin
                forget_all_scopes();
            end
        endcase
        r.depth = stack_level;
        return r;
    endfunction

    task automatic drop_valid();
        if (cmd_up)
        begin
            req_if.valid <= 1'b0;
            cmd_up = 1'b0;
        end
    endtask

    task automatic issue_command(op_t op, logic [SID_W-1:0] sid);
        if (!cmd_up)
        begin
            req_if.valid <= 1'b1;
            cmd_up = 1'b1;
        end
        req_if.cmd       <= op;
        req_if.target_id <= sid;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        pending_results.push_back(track_command(op, sid));
        if (bursty)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                drop_valid();
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_drained();
        drop_valid();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic compare_field(string fname, int unsigned want, int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d actual %0d",
                     $time, fname, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        scope_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t ns: result transaction with none expected, %s %0d %0d %0d",
                         $time, "actual new_scope status depth",
                         res_ch.new_scope, res_ch.status, res_ch.depth);
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("new_scope", want.new_scope, res_ch.new_scope);
                compare_field("valid_res", want.valid_res, res_ch.valid_res);
                compare_field("status", want.status, res_ch.status);
                compare_field("popped_id", want.popped_id, res_ch.popped_id);
                compare_field("depth", want.depth, res_ch.depth);
            end
        end
    end

    always @(posedge clk)
    begin
        sink_phase <= sink_phase + 1'b1;
        case (sink_mode)
            SINK_OPEN:   sink_ready <= 1'b1;
            SINK_RANDOM: sink_ready <= ($urandom_range(0, 3) != 0);
            default:     sink_ready <= STALL_PATTERN[sink_phase];
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_scope_lifetime_tracker: FAIL");
            $finish;
        end
    end

    task automatic test_idle_after_reset();
        bursty = 1'b0;
        sink_mode <= SINK_OPEN;
        issue_command(OP_CHECK, 10'd1);
        issue_command(OP_CHECK, 10'd0);
        issue_command(OP_CHECK, 10'h3FF);
        issue_command(OP_EXIT, 10'd5);
        issue_command(OP_CLEAR, 10'h3FF);
        wait_drained();
    endtask

    task automatic test_nesting();
        sink_mode <= SINK_RANDOM;
        repeat (3) issue_command(OP_ENTER, 10'h3FF);
        issue_command(OP_CHECK, 10'd2);
        issue_command(OP_EXIT, 10'd3);
        issue_command(OP_EXIT, 10'd2);
        issue_command(OP_CHECK, 10'd2);
        issue_command(OP_CHECK, 10'd1);
        issue_command(OP_EXIT, 10'd1);
        wait_drained();
    endtask

    task automatic test_exit_mismatch();
        sink_mode <= SINK_PATTERN;
        repeat (2) issue_command(OP_ENTER, 10'd0);
        // wrong order: top stays active, given id is cleared
        issue_command(OP_EXIT, 10'd4);
        issue_command(OP_CHECK, 10'd5);
        issue_command(OP_CHECK, 10'd4);
        // invalid identifiers on exit
        issue_command(OP_ENTER, 10'd0);
        issue_command(OP_EXIT, 10'd0);
        issue_command(OP_ENTER, 10'd0);
        issue_command(OP_EXIT, 10'd512);
        issue_command(OP_EXIT, 10'h3FF);
        issue_command(OP_EXIT, 10'd7);
        issue_command(OP_CHECK, 10'd511);
        issue_command(OP_CHECK, 10'd512);
        wait_drained();
    endtask

    task automatic test_clear();
        sink_mode <= SINK_OPEN;
        repeat (3) issue_command(OP_ENTER, 10'd0);
        issue_command(OP_CLEAR, 10'd0);
        issue_command(OP_CHECK, 10'd1);
        issue_command(OP_ENTER, 10'h2AA);
        issue_command(OP_CHECK, 10'd1);
        issue_command(OP_CLEAR, 10'h155);
        wait_drained();
    endtask

    task automatic test_overflow_and_wrap();
        bursty = 1'b1;
        sink_mode <= SINK_PATTERN;
        issue_command(OP_CLEAR, 10'd0);
        // fills the stack; the last enter wraps the counter and reuses id one
        repeat (MAX_SCOPES) issue_command(OP_ENTER, SID_W'($urandom_range(0, 1023)));
        issue_command(OP_ENTER, 10'd0);
        issue_command(OP_CHECK, 10'd1);
        issue_command(OP_CHECK, SID_W'(MAX_SCOPES - 1));
        // overflow must have left the counter alone
        issue_command(OP_EXIT, {1'b0, id_stack[stack_level - 1'b1]});
        issue_command(OP_ENTER, 10'd0);
        while (stack_level != 0)
            issue_command(OP_EXIT, {1'b0, id_stack[stack_level - 1'b1]});
        issue_command(OP_EXIT, 10'd0);
        wait_drained();
    endtask

    task automatic run_random_phase(int unsigned n_items, int unsigned enter_pct,
                                    int unsigned clear_pct, bit gaps, sink_mode_t smode);
        int unsigned      roll;
        int unsigned      exit_top;
        logic [SID_W-1:0] sid;
        bursty = gaps;
        sink_mode <= smode;
        exit_top = clear_pct + enter_pct + (100 - clear_pct - enter_pct) * 6 / 10;
        repeat (n_items)
        begin
            roll = $urandom_range(0, 99);
            sid  = $urandom_range(0, 1023);
            if (roll < clear_pct)
            begin
                issue_command(OP_CLEAR, sid);
            end
            else if (roll < clear_pct + enter_pct)
            begin
                issue_command(OP_ENTER, sid);
            end
            else if (roll < exit_top)
            begin
                // mostly properly nested exits
                if (stack_level != 0 && $urandom_range(0, 9) < 8)
                    sid = {1'b0, id_stack[stack_level - 1'b1]};
                issue_command(OP_EXIT, sid);
            end
            else
            begin
                if (stack_level != 0 && $urandom_range(0, 9) < 6)
                    sid = {1'b0, id_stack[$urandom_range(0, stack_level - 1)]};
                issue_command(OP_CHECK, sid);
            end
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_if.valid     <= 1'b0;
        req_if.cmd       <= OP_ENTER;
        req_if.target_id <= '0;
        forget_all_scopes();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_after_reset();
        test_nesting();
        test_exit_mismatch();
        test_clear();
        test_overflow_and_wrap();
        run_random_phase(180, 40, 2, 1'b1, SINK_RANDOM);
        run_random_phase(180, 60, 0, 1'b1, SINK_PATTERN);
        run_random_phase(180, 38, 2, 1'b0, SINK_OPEN);
        run_random_phase(180, 30, 3, 1'b1, SINK_RANDOM);

        wait_drained();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("tb_scope_lifetime_tracker: PASS");
        else
            $display("tb_scope_lifetime_tracker: FAIL");
        $finish;
    end

endmodule
